### sv/ttb_pkg.sv
// ttb_pkg: shared widths and the job and result records for the tangent/bitangent block
// no dependencies
`default_nettype none
package ttb_pkg;
    localparam int POS_W    = 32;
    localparam int UV_W     = 16;
    localparam int OUT_FRAC = 14;
    localparam int OUT_W    = 16;
    localparam int DP_W     = POS_W + 1;
    localparam int DUV_W    = UV_W + 1;
    localparam int PROD_W   = DP_W + DUV_W;
    localparam int VEC_W    = PROD_W + 1;
    localparam int DET_W    = 2 * DUV_W + 1;
    localparam int NORM_W   = 30;
    localparam int SUM_W    = 2 * NORM_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int Q_W      = OUT_FRAC + 1;
    localparam int NUM_W    = NORM_W + OUT_FRAC + 1;

    typedef struct packed {
        logic [2:0][DP_W-1:0] dp1;
        logic [2:0][DP_W-1:0] dp2;
        logic [DUV_W-1:0]     du1;
        logic [DUV_W-1:0]     dv1;
        logic [DUV_W-1:0]     du2;
        logic [DUV_W-1:0]     dv2;
    } t_job;

    typedef struct packed {
        logic [2:0][OUT_W-1:0] tan;
        logic [2:0][OUT_W-1:0] bitan;
        logic                  degen;
    } t_res;
endpackage
`default_nettype wire

### sv/triangle_tangent_bitangent.sv
// triangle_tangent_bitangent: unit tangent and bitangent per triangle
// depends on ttb_pkg, ttb_front, ttb_fifo, ttb_back
//
// vertices come in one request each on the push/full side; every third
// vertex closes a triangle and yields one result on the empty/pop side
// a vertex is taken when push is high and full is low; a result is taken
// when pop is high and empty is low, and it stays on the ports until then
// the front stores corners and forms the deltas combinationally, pushing the
// triangle into a two-entry queue as its third vertex is taken; the back pops
// it when idle, runs one shared multiplier for the determinant and the six
// vector components, then per vector a load step, a shift search, a square
// sum of the three components, a square root and three divisions, and a step
// to place the result; the back works on one triangle at a time
// a degenerate triangle ends early and gives zero vectors with the flag set
// when pop is held low the result waits, the back holds its finished work,
// and full rises once the queue holds two triangles
// reset clears the corner count, the queue, the back's state and the result valid flag
`default_nettype none
module triangle_tangent_bitangent import ttb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [POS_W-1:0] i_pos_x,
    input  wire logic [POS_W-1:0] i_pos_y,
    input  wire logic [POS_W-1:0] i_pos_z,
    input  wire logic [UV_W-1:0]  i_tex_u,
    input  wire logic [UV_W-1:0]  i_tex_v,
    output logic                  empty,
    input  wire logic             pop,
    output logic [OUT_W-1:0]      o_tangent_x,
    output logic [OUT_W-1:0]      o_tangent_y,
    output logic [OUT_W-1:0]      o_tangent_z,
    output logic [OUT_W-1:0]      o_bitangent_x,
    output logic [OUT_W-1:0]      o_bitangent_y,
    output logic [OUT_W-1:0]      o_bitangent_z,
    output logic                  o_degenerate
);
    t_job w_job_in, w_job_out;
    logic w_push, w_pop, w_qempty;
    t_res w_res;

    ttb_front u_front (
        .i_clk, .i_rst_n,
        .i_accept   (push && !full),
        .i_pos_x, .i_pos_y, .i_pos_z, .i_tex_u, .i_tex_v,
        .o_job      (w_job_in),
        .o_job_push (w_push)
    );

    ttb_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_qempty)
    );

    ttb_back u_back (
        .i_clk, .i_rst_n,
        .i_job_empty (w_qempty),
        .i_job       (w_job_out),
        .o_job_pop   (w_pop),
        .o_res       (w_res),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_tangent_x   = w_res.tan[0];
    assign o_tangent_y   = w_res.tan[1];
    assign o_tangent_z   = w_res.tan[2];
    assign o_bitangent_x = w_res.bitan[0];
    assign o_bitangent_y = w_res.bitan[1];
    assign o_bitangent_z = w_res.bitan[2];
    assign o_degenerate  = w_res.degen;
endmodule
`default_nettype wire

### sv/ttb_front.sv
// ttb_front: holds the first two corners and forms the deltas on the third
// depends on ttb_pkg
`default_nettype none
module ttb_front import ttb_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [POS_W-1:0] i_pos_x,
    input  wire logic [POS_W-1:0] i_pos_y,
    input  wire logic [POS_W-1:0] i_pos_z,
    input  wire logic [UV_W-1:0]  i_tex_u,
    input  wire logic [UV_W-1:0]  i_tex_v,
    output t_job                  o_job,
    output logic                  o_job_push
);
    logic [1:0]                 r_cnt, n_cnt;
    logic [1:0][2:0][POS_W-1:0] r_pos;
    logic [1:0][UV_W-1:0]       r_u, r_v;
    logic [2:0][POS_W-1:0]      w_p;

    assign w_p = {i_pos_z, i_pos_y, i_pos_x};

    always_comb begin
        n_cnt = r_cnt;
        o_job_push = 1'b0;
        if (i_accept) begin
            if (r_cnt == 2'd2) begin
                n_cnt = 2'd0;
                o_job_push = 1'b1;
            end else begin
                n_cnt = r_cnt + 2'd1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            o_job.dp1[i] = {r_pos[1][i][POS_W-1], r_pos[1][i]}
                         - {r_pos[0][i][POS_W-1], r_pos[0][i]};
            o_job.dp2[i] = {w_p[i][POS_W-1], w_p[i]}
                         - {r_pos[0][i][POS_W-1], r_pos[0][i]};
        end
        o_job.du1 = {r_u[1][UV_W-1], r_u[1]} - {r_u[0][UV_W-1], r_u[0]};
        o_job.dv1 = {r_v[1][UV_W-1], r_v[1]} - {r_v[0][UV_W-1], r_v[0]};
        o_job.du2 = {i_tex_u[UV_W-1], i_tex_u} - {r_u[0][UV_W-1], r_u[0]};
        o_job.dv2 = {i_tex_v[UV_W-1], i_tex_v} - {r_v[0][UV_W-1], r_v[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && r_cnt != 2'd2) begin
            r_pos[r_cnt[0]] <= w_p;
            r_u[r_cnt[0]]   <= i_tex_u;
            r_v[r_cnt[0]]   <= i_tex_v;
        end
    end
endmodule
`default_nettype wire

### sv/ttb_fifo.sv
// ttb_fifo: two-entry job queue between front and back
// depends on ttb_pkg
`default_nettype none
module ttb_fifo import ttb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output t_job      o_data,
    output logic      o_empty
);
    t_job [1:0] r_mem;
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_pop && !o_empty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

### sv/ttb_back.sv
// ttb_back: products, normalize shift, square sum, square root and division
// depends on ttb_pkg
`default_nettype none
module ttb_back import ttb_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_empty,
    input  t_job      i_job,
    output logic      o_job_pop,
    output t_res      o_res,
    output logic      o_empty,
    input  wire logic i_pop
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_LOAD  = 4'd2;
    localparam logic [3:0] S_NORM  = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_DIVLD = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_PUT   = 4'd8;

    logic [3:0]              r_st;
    logic [4:0]              r_cnt;
    logic [1:0]              r_comp;
    logic                    r_pass;
    logic                    r_degen;
    t_job                    r_job;
    logic [PROD_W-1:0]       r_acc;
    logic [DET_W-1:0]        r_det;
    logic [5:0][VEC_W-1:0]   r_vec;
    logic [2:0][VEC_W-1:0]   r_m;
    logic [2:0]              r_neg;
    logic [SUM_W-1:0]        r_s;
    logic [ROOT_W+1:0]       r_rem;
    logic [ROOT_W-1:0]       r_root;
    logic [ROOT_W-1:0]       r_rr;
    logic [Q_W-1:0]          r_num;
    logic [Q_W-1:0]          r_q;
    logic [5:0][OUT_W-1:0]   r_res;
    logic                    r_ovalid;
    t_res                    r_out;

    logic [2:0]              w_idx;
    logic [1:0]              w_c;
    logic [DP_W-1:0]         w_a;
    logic [DUV_W-1:0]        w_b;
    logic [PROD_W-1:0]       w_prod;
    logic [VEC_W-1:0]        w_diff;
    logic [VEC_W-1:0]        w_or;
    logic [2:0][VEC_W-1:0]   w_v;
    logic [2*NORM_W-1:0]     w_sq;
    logic [ROOT_W+3:0]       w_trial;
    logic [NUM_W-1:0]        w_numer;
    logic [ROOT_W:0]         w_dt;
    logic [Q_W-1:0]          w_qn;
    logic [2:0]              w_ridx;
    logic                    w_put;

    assign w_idx = r_cnt[3:1];
    assign w_c   = 2'(w_idx - 3'd1 >> 1);

    always_comb begin
        w_a = '0;
        w_b = '0;
        if (w_idx == 3'd0) begin
            w_a = r_cnt[0] ? {{(DP_W-DUV_W){r_job.dv1[DUV_W-1]}}, r_job.dv1}
                           : {{(DP_W-DUV_W){r_job.du1[DUV_W-1]}}, r_job.du1};
            w_b = r_cnt[0] ? r_job.du2 : r_job.dv2;
        end else if (w_c != 2'd3) begin
            if (w_idx[0]) begin
                w_a = r_cnt[0] ? r_job.dp2[w_c] : r_job.dp1[w_c];
                w_b = r_cnt[0] ? r_job.dv1 : r_job.dv2;
            end else begin
                w_a = r_cnt[0] ? r_job.dp1[w_c] : r_job.dp2[w_c];
                w_b = r_cnt[0] ? r_job.du2 : r_job.du1;
            end
        end
    end

    assign w_prod = PROD_W'($signed(w_a) * $signed(w_b));
    assign w_diff = {r_acc[PROD_W-1], r_acc} - {w_prod[PROD_W-1], w_prod};
    assign w_or   = r_m[0] | r_m[1] | r_m[2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i] = r_vec[2 * i + int'(r_pass)];
        end
    end

    assign w_sq    = r_m[r_cnt[1:0]][NORM_W-1:0] * r_m[r_cnt[1:0]][NORM_W-1:0];
    assign w_trial = {r_rem, r_s[SUM_W-1 -: 2]} - {2'b00, r_root, 2'b01};
    assign w_numer = {1'b0, r_m[r_comp][NORM_W-1:0], {OUT_FRAC{1'b0}}}
                   + {{(NUM_W-ROOT_W+1){1'b0}}, r_root[ROOT_W-1:1]};
    assign w_dt    = {r_rr, r_num[Q_W-1]};
    assign w_qn    = {r_q[Q_W-2:0], w_dt >= {1'b0, r_root}};
    assign w_ridx  = {r_pass, 2'b00} - {2'b00, r_pass} + {1'b0, r_comp};
    assign w_put   = (r_st == S_PUT) && (!r_ovalid || i_pop);

    assign o_job_pop = (r_st == S_IDLE) && !i_job_empty;
    assign o_empty   = !r_ovalid;
    assign o_res     = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (w_put) begin
                r_ovalid <= 1'b1;
            end else if (i_pop) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE:  if (!i_job_empty) r_st <= S_MUL;
                S_MUL: begin
                    if (r_cnt == 5'd13) r_st <= (r_det == '0) ? S_PUT : S_LOAD;
                end
                S_LOAD:  r_st <= S_NORM;
                S_NORM: begin
                    if (w_or == '0) r_st <= S_PUT;
                    else if (w_or[VEC_W-1:NORM_W] == '0 && w_or[NORM_W-1]) r_st <= S_SQ;
                end
                S_SQ:    if (r_cnt == 5'd2) r_st <= S_SQRT;
                S_SQRT:  if (r_cnt == 5'(ROOT_W - 1)) r_st <= S_DIVLD;
                S_DIVLD: r_st <= S_DIV;
                S_DIV: begin
                    if (r_cnt == 5'(Q_W - 1)) begin
                        if (r_comp != 2'd2) r_st <= S_DIVLD;
                        else r_st <= r_pass ? S_PUT : S_LOAD;
                    end
                end
                S_PUT:   if (w_put) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_job   <= i_job;
                r_cnt   <= '0;
                r_pass  <= 1'b0;
                r_degen <= 1'b0;
            end
            S_MUL: begin
                r_cnt <= r_cnt + 5'd1;
                r_acc <= w_prod;
                if (r_cnt[0]) begin
                    if (w_idx == 3'd0) r_det <= w_diff[DET_W-1:0];
                    else r_vec[w_idx - 3'd1] <= w_diff;
                end
                if (r_cnt == 5'd13 && r_det == '0) r_degen <= 1'b1;
            end
            S_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= w_v[i][VEC_W-1] ? VEC_W'(-w_v[i]) : w_v[i];
                    r_neg[i] <= w_v[i][VEC_W-1] ^ r_det[DET_W-1];
                end
            end
            S_NORM: begin
                r_cnt <= '0;
                r_s   <= '0;
                if (w_or == '0) begin
                    r_degen <= 1'b1;
                end else if (w_or[VEC_W-1:NORM_W] != '0) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                end else if (!w_or[NORM_W-1]) begin
                    for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
                end
            end
            S_SQ: begin
                r_s    <= r_s + {2'b00, w_sq};
                r_cnt  <= (r_cnt == 5'd2) ? 5'd0 : r_cnt + 5'd1;
                r_rem  <= '0;
                r_root <= '0;
            end
            S_SQRT: begin
                r_s <= r_s << 2;
                if (!w_trial[ROOT_W+3]) begin
                    r_rem  <= w_trial[ROOT_W+1:0];
                    r_root <= {r_root[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem  <= {r_rem[ROOT_W-1:0], r_s[SUM_W-1 -: 2]};
                    r_root <= {r_root[ROOT_W-2:0], 1'b0};
                end
                r_cnt  <= (r_cnt == 5'(ROOT_W - 1)) ? 5'd0 : r_cnt + 5'd1;
                r_comp <= 2'd0;
            end
            S_DIVLD: begin
                r_rr  <= ROOT_W'(w_numer[NUM_W-1:Q_W]);
                r_num <= w_numer[Q_W-1:0];
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_num <= r_num << 1;
                r_q   <= w_qn;
                r_rr  <= w_qn[0] ? ROOT_W'(w_dt - {1'b0, r_root}) : w_dt[ROOT_W-1:0];
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(Q_W - 1)) begin
                    r_res[w_ridx] <= r_neg[r_comp] ? OUT_W'(-{1'b0, w_qn})
                                                   : OUT_W'({1'b0, w_qn});
                    r_comp <= r_comp + 2'd1;
                    if (r_comp == 2'd2) r_pass <= 1'b1;
                end
            end
            S_PUT: begin
                if (w_put) begin
                    r_out.degen <= r_degen;
                    for (int i = 0; i < 3; i++) begin
                        r_out.tan[i]   <= r_degen ? '0 : r_res[i];
                        r_out.bitan[i] <= r_degen ? '0 : r_res[3 + i];
                    end
                end
            end
            default: r_cnt <= '0;
        endcase
    end
endmodule
`default_nettype wire

### dv/triangle_tangent_bitangent_test.sv
// triangle_tangent_bitangent_test: self-checking bench for the tangent/bitangent block
// depends on ttb_pkg and triangle_tangent_bitangent; predicts each triangle's unit
// tangent and bitangent in 64-bit integer math and checks every popped result
`default_nettype none
module triangle_tangent_bitangent_test import ttb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] tx, ty, tz, bx, by, bz;
        logic        degen;
    } t_basis;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [UV_W-1:0] i_tex_u = '0, i_tex_v = '0;
    logic [OUT_W-1:0] o_tangent_x, o_tangent_y, o_tangent_z;
    logic [OUT_W-1:0] o_bitangent_x, o_bitangent_y, o_bitangent_z;
    logic o_degenerate;

    triangle_tangent_bitangent u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_tex_u(i_tex_u), .i_tex_v(i_tex_v), .empty(empty), .pop(pop),
        .o_tangent_x(o_tangent_x), .o_tangent_y(o_tangent_y),
        .o_tangent_z(o_tangent_z), .o_bitangent_x(o_bitangent_x),
        .o_bitangent_y(o_bitangent_y), .o_bitangent_z(o_bitangent_z),
        .o_degenerate(o_degenerate)
    );

    always #5 i_clk = ~i_clk;

    t_basis expected_basis[$];
    logic [63:0] held_pos[6];
    logic [63:0] held_uv[4];
    int corners_held = 0;
    int mismatches = 0;
    int vertices_sent = 0;
    int triangles_checked = 0;
    int degenerate_seen = 0;
    int idle_cycles = 0;
    bit send_idling = 1'b1;
    bit recv_idling = 1'b1;
    int recv_hold = 0;
    int holds_asked = 0;
    int holds_done = 0;

    function automatic logic [63:0] isqrt(logic [63:0] s);
        logic [63:0] res, bt;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > s) bt >>= 2;
        while (bt != 0) begin
            if (s >= res + bt) begin
                s -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic bit unit_vector(input logic [63:0] v[3], output logic [15:0] o[3]);
        logic [63:0] m[3];
        logic [63:0] mx, s, len, q;
        int nb;
        mx = 0;
        s = 0;
        nb = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = v[i][63] ? -v[i] : v[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 1'b0;
        while (nb < 64 && (mx >> nb) != 0) nb++;
        for (int i = 0; i < 3; i++) begin
            if (nb > 30) m[i] >>= (nb - 30);
            else m[i] <<= (30 - nb);
            s += m[i] * m[i];
        end
        len = isqrt(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << OUT_FRAC) + (len >> 1)) / len;
            if (v[i][63]) q = -q;
            o[i] = q[15:0];
        end
        return 1'b1;
    endfunction

    function automatic void predict_vertex(logic [31:0] px, py, pz, logic [15:0] u, v);
        logic [63:0] p[3];
        logic [63:0] uu, vv, du1, dv1, du2, dv2, det;
        logic [63:0] dp1[3], dp2[3], t[3], b[3];
        logic [15:0] to[3], bo[3];
        bit okt, okb;
        t_basis r;
        p[0] = {{32{px[31]}}, px};
        p[1] = {{32{py[31]}}, py};
        p[2] = {{32{pz[31]}}, pz};
        uu = {{48{u[15]}}, u};
        vv = {{48{v[15]}}, v};
        if (corners_held < 2) begin
            for (int i = 0; i < 3; i++) held_pos[corners_held*3+i] = p[i];
            held_uv[corners_held*2] = uu;
            held_uv[corners_held*2+1] = vv;
            corners_held++;
            return;
        end
        corners_held = 0;
        du1 = held_uv[2] - held_uv[0];
        dv1 = held_uv[3] - held_uv[1];
        du2 = uu - held_uv[0];
        dv2 = vv - held_uv[1];
        det = du1 * dv2 - dv1 * du2;
        for (int i = 0; i < 3; i++) begin
            dp1[i] = held_pos[3+i] - held_pos[i];
            dp2[i] = p[i] - held_pos[i];
            t[i] = dp1[i] * dv2 - dp2[i] * dv1;
            b[i] = dp2[i] * du1 - dp1[i] * du2;
            if (det[63]) begin
                t[i] = -t[i];
                b[i] = -b[i];
            end
        end
        okt = unit_vector(t, to);
        okb = unit_vector(b, bo);
        if (det == 0 || !okt || !okb) r = '{default: 0, degen: 1'b1};
        else r = '{tx: to[0], ty: to[1], tz: to[2], bx: bo[0], by: bo[1], bz: bo[2],
                   degen: 1'b0};
        expected_basis.push_back(r);
    endfunction

    task automatic send_vertex(logic [31:0] px, py, pz, logic [15:0] u, v);
        if (send_idling && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pos_x <= px;
        i_pos_y <= py;
        i_pos_z <= pz;
        i_tex_u <= u;
        i_tex_v <= v;
        do @(posedge i_clk); while (full);
        predict_vertex(px, py, pz, u, v);
        vertices_sent++;
    endtask

    function automatic logic [31:0] rand_pos(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 2047) - 1024;
            default: return {{8{1'b0}}, 24'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
        endcase
    endfunction

    task automatic send_triangle(int mode);
        for (int k = 0; k < 3; k++)
            send_vertex(rand_pos(mode), rand_pos(mode), rand_pos(mode),
                        (mode == 1) ? 16'($urandom_range(0, 63)) : 16'($urandom),
                        (mode == 1) ? 16'($urandom_range(0, 63)) : 16'($urandom));
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_basis.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h0, 16'h8000, 16'h7fff);
        send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 16'h7fff, 16'h8000);
        send_vertex(32'h0, 32'h0, 32'h7fff_ffff, 16'h8000, 16'h8000);
        send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'h7fff, 16'h7fff);
        send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h7fff);
        send_vertex(32'hffff_ffff, 32'h0, 32'h1, 16'h7fff, 16'h8000);
        // two small triangles, the first with positive, the second with negative determinant
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
        send_vertex(32'h1_0000, 32'h0, 32'h0, 16'h1000, 16'h0);
        send_vertex(32'h0, 32'h1_0000, 32'h0, 16'h0, 16'h1000);
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
        send_vertex(32'h1_0000, 32'h0, 32'h0, 16'h0, 16'h1000);
        send_vertex(32'h0, 32'h1_0000, 32'h0, 16'h1000, 16'h0);
        drain();
    endtask

    task automatic test_degenerate();
        // zero determinant: collinear uv
        send_vertex(32'h5, 32'h7, 32'h9, 16'h10, 16'h10);
        send_vertex(32'h100, 32'h3, 32'h0, 16'h20, 16'h20);
        send_vertex(32'h0, 32'h400, 32'h1, 16'h30, 16'h30);
        // zero vectors: all corners at the same position
        send_vertex(32'h1234, 32'h1234, 32'h1234, 16'h0, 16'h0);
        send_vertex(32'h1234, 32'h1234, 32'h1234, 16'h100, 16'h0);
        send_vertex(32'h1234, 32'h1234, 32'h1234, 16'h0, 16'h100);
        // corners and uv one unit apart give nonzero t and b along x and z, the tiny case
        send_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0);
        send_vertex(32'h1, 32'h0, 32'h0, 16'h1, 16'h0);
        send_vertex(32'h0, 32'h0, 32'h1, 16'h0, 16'h1);
        drain();
    endtask

    task automatic test_random(int triangles);
        for (int n = 0; n < triangles; n++) send_triangle($urandom_range(0, 2));
        drain();
    endtask

    task automatic test_backpressure();
        holds_asked++;
        for (int n = 0; n < 6; n++) send_triangle(1);
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_done + 1;
            recv_hold <= 1500;
            pop <= 1'b0;
        end else if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            pop <= 1'b0;
        end else if (recv_idling && $urandom_range(0, 5) == 0) begin
            recv_hold <= $urandom_range(1, 15);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_basis got, want;
        if (i_rst_n && pop && !empty) begin
            got = '{tx: o_tangent_x, ty: o_tangent_y, tz: o_tangent_z, bx: o_bitangent_x,
                    by: o_bitangent_y, bz: o_bitangent_z, degen: o_degenerate};
            if (expected_basis.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
                want = expected_basis.pop_front();
                triangles_checked++;
                if (want.degen) degenerate_seen++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_degenerate();
        test_backpressure();
        test_random(500);
        send_idling = 1'b0;
        recv_idling = 1'b0;
        test_random(110);
        repeat (300) @(posedge i_clk);
        $display("sent %0d vertices, checked %0d triangles, %0d degenerate",
                 vertices_sent, triangles_checked, degenerate_seen);
        if (mismatches == 0 && expected_basis.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
sv/ttb_pkg.sv
sv/ttb_front.sv
sv/ttb_fifo.sv
sv/ttb_back.sv
sv/triangle_tangent_bitangent.sv
dv/triangle_tangent_bitangent_test.sv
